FILE: rtl/bsm_pkg.sv
// Shared types and constants of the bank switch mapper.
package bsm_pkg;

  // Kind of one slot update on the result ports.
  typedef enum logic [1:0] {
    KIND_PRG    = 2'd0,
    KIND_CHR    = 2'd1,
    KIND_MIRROR = 2'd2,
    KIND_IRQ    = 2'd3
  } kind_e;

  typedef logic [7:0] bank_t;
  typedef bank_t [7:0] bank_vec_t;
  typedef bank_t [5:0] chr_regs_t;

  // One run of slot updates handed from the decoder to the sequencer.
  typedef struct packed {
    kind_e     kind;
    logic [2:0] first_slot;
    logic [2:0] last_idx;
    bank_vec_t banks;
  } job_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PRG_COUNT   = 2'd0;
  localparam logic [1:0] CFG_CHR_PRESENT = 2'd1;
  localparam logic [1:0] CFG_FOUR_SCREEN = 2'd2;
  localparam int unsigned CFG_WIDTH      = 9;

  // Decoded bus addresses.
  localparam logic [15:0] ADDR_EXT_MODE   = 16'h5000;
  localparam logic [15:0] ADDR_BANK_SEL   = 16'h8000;
  localparam logic [15:0] ADDR_BANK_DATA  = 16'h8001;
  localparam logic [15:0] ADDR_EXT_ENABLE = 16'h8003;
  localparam logic [15:0] ADDR_MIRROR     = 16'hA000;
  localparam logic [15:0] ADDR_IRQ_COUNT  = 16'hC000;
  localparam logic [15:0] ADDR_IRQ_RELOAD = 16'hC001;
  localparam logic [15:0] ADDR_IRQ_OFF_A  = 16'hE000;
  localparam logic [15:0] ADDR_IRQ_ON_A   = 16'hE001;
  localparam logic [15:0] ADDR_IRQ_OFF_B  = 16'hE002;
  localparam logic [15:0] ADDR_IRQ_ON_B   = 16'hE003;

  // Extended-mode constants.
  localparam bank_t EXT_SEL_SLOT1  = 8'h2A;
  localparam bank_t EXT_SEL_SLOT2  = 8'h28;
  localparam bank_t EXT_BANK_SLOT1 = 8'h0F;
  localparam bank_t EXT_BANK_SLOT2 = 8'h17;
  localparam bank_t EXT_LOCK_MASK  = 8'hA0;

  localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;

endpackage

FILE: rtl/bsm_front.sv
// Front end: configuration, bus write and scanline tick decoding, mapper state and run building.
module bsm_front
  import bsm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [CFG_WIDTH-1:0] cfg_wdata_i,
  input  logic                 accept_i,
  input  logic                 action_i,
  input  logic [15:0]          bus_address_i,
  input  logic [7:0]           bus_data_i,
  input  logic [8:0]           line_number_i,
  input  logic                 rendering_on_i,
  output job_t                 job_o,
  output logic                 job_push_o
);

  localparam chr_regs_t CHR_RESET = {8'd7, 8'd6, 8'd5, 8'd4, 8'd2, 8'd0};

  logic [8:0] prg_count_q;
  logic       chr_present_q;
  logic       four_screen_q;

  bank_t      bank_select_q, bank_select_d;
  logic       ext_enabled_q, ext_enabled_d;
  bank_t      ext_mode_q, ext_mode_d;
  bank_t      prg_a_q, prg_a_d;
  bank_t      prg_b_q, prg_b_d;
  bank_t      ext_prg_a_q, ext_prg_a_d;
  bank_t      ext_prg_b_q, ext_prg_b_d;
  chr_regs_t  chr_q, chr_d;
  logic       irq_on_q, irq_on_d;
  bank_t      irq_count_q, irq_count_d;
  bank_t      irq_reload_q, irq_reload_d;

  bank_t      fixed2, fixed1, ext_base;
  logic [2:0] sel;
  job_t       job;
  logic       job_valid;

  // Eight 1K character slots; bit 7 of bank select swaps the two halves.
  function automatic bank_vec_t chr_layout(input logic swap, input chr_regs_t r);
    bank_vec_t lo;
    bank_vec_t v;
    lo = '0;
    v  = '0;
    lo[0] = r[0];
    lo[1] = r[0] + 8'd1;
    lo[2] = r[1];
    lo[3] = r[1] + 8'd1;
    for (int i = 0; i < 4; i++) begin
      v[i]     = swap ? r[2+i] : lo[i];
      v[4 + i] = swap ? lo[i] : r[2+i];
    end
    return v;
  endfunction

  function automatic bank_vec_t prg_four(input bank_t b0, input bank_t b1,
                                         input bank_t b2, input bank_t b3);
    bank_vec_t v;
    v = '0;
    v[0] = b0;
    v[1] = b1;
    v[2] = b2;
    v[3] = b3;
    return v;
  endfunction

  assign fixed2 = prg_count_q[7:0] - 8'd2;
  assign fixed1 = prg_count_q[7:0] - 8'd1;

  always_comb begin
    bank_select_d = bank_select_q;
    ext_enabled_d = ext_enabled_q;
    ext_mode_d    = ext_mode_q;
    prg_a_d       = prg_a_q;
    prg_b_d       = prg_b_q;
    ext_prg_a_d   = ext_prg_a_q;
    ext_prg_b_d   = ext_prg_b_q;
    chr_d         = chr_q;
    irq_on_d      = irq_on_q;
    irq_count_d   = irq_count_q;
    irq_reload_d  = irq_reload_q;
    job           = '0;
    job.kind      = KIND_PRG;
    job_valid     = 1'b0;
    sel           = bank_select_q[2:0];
    ext_base      = '0;

    if (action_i) begin
      // Scanline tick: count only on visible lines with rendering on.
      if (irq_on_q && (line_number_i <= LAST_VISIBLE_LINE) && rendering_on_i) begin
        if (irq_count_q == 8'd0) begin
          irq_count_d = irq_reload_q;
          job.kind    = KIND_IRQ;
          job_valid   = 1'b1;
        end else begin
          irq_count_d = irq_count_q - 8'd1;
        end
      end
    end else begin
      case (bus_address_i)
        ADDR_EXT_MODE: begin
          ext_mode_d = bus_data_i;
          job_valid  = 1'b1;
          job.last_idx = 3'd3;
          if (bus_data_i[7]) begin
            if (bus_data_i[5]) begin
              ext_base  = {2'b00, bus_data_i[4:1], 2'b00};
              job.banks = prg_four(ext_base, ext_base + 8'd1, ext_base + 8'd2,
                                   ext_base + 8'd3);
            end else begin
              ext_base       = {2'b00, bus_data_i[4:0], 1'b0};
              job.first_slot = 3'd1;
              job.last_idx   = 3'd1;
              job.banks[0]   = ext_base;
              job.banks[1]   = ext_base + 8'd1;
            end
          end else begin
            job.banks = prg_four(ext_prg_a_q, ext_prg_b_q, fixed2, fixed1);
          end
        end
        ADDR_BANK_SEL: begin
          ext_enabled_d = 1'b0;
          bank_select_d = bus_data_i;
          if (chr_present_q) begin
            job.kind     = KIND_CHR;
            job.last_idx = 3'd7;
            job.banks    = chr_layout(bus_data_i[7], chr_q);
            job_valid    = 1'b1;
          end
        end
        ADDR_BANK_DATA: begin
          if (ext_enabled_q) begin
            if (bank_select_q == EXT_SEL_SLOT1) begin
              job.first_slot = 3'd1;
              job.banks[0]   = EXT_BANK_SLOT1;
              job_valid      = 1'b1;
            end else if (bank_select_q == EXT_SEL_SLOT2) begin
              job.first_slot = 3'd2;
              job.banks[0]   = EXT_BANK_SLOT2;
              job_valid      = 1'b1;
            end
          end else if (sel <= 3'd5) begin
            if (chr_present_q) begin
              chr_d[sel]   = (sel <= 3'd1) ? {bus_data_i[7:1], 1'b0} : bus_data_i;
              job.kind     = KIND_CHR;
              job.last_idx = 3'd7;
              job.banks    = chr_layout(bank_select_q[7], chr_d);
              job_valid    = 1'b1;
            end
          end else begin
            if (sel == 3'd6) begin
              ext_prg_a_d = bus_data_i;
            end else begin
              ext_prg_b_d = bus_data_i;
            end
            if ((ext_mode_q & EXT_LOCK_MASK) != EXT_LOCK_MASK) begin
              if (sel == 3'd6) begin
                prg_a_d = bus_data_i;
              end else begin
                prg_b_d = bus_data_i;
              end
              job.last_idx = 3'd3;
              job_valid    = 1'b1;
              if (bank_select_q[6]) begin
                job.banks = prg_four(fixed2, prg_b_d, prg_a_d, fixed1);
              end else begin
                job.banks = prg_four(prg_a_d, prg_b_d, fixed2, fixed1);
              end
            end
          end
        end
        ADDR_EXT_ENABLE: begin
          ext_enabled_d = 1'b1;
          if (bus_data_i[7:4] == 4'd0) begin
            job.first_slot = 3'd2;
            job.banks[0]   = fixed2;
            job_valid      = 1'b1;
          end
        end
        ADDR_MIRROR: begin
          if (!four_screen_q) begin
            job.kind     = KIND_MIRROR;
            job.banks[0] = {7'd0, bus_data_i[0]};
            job_valid    = 1'b1;
          end
        end
        ADDR_IRQ_COUNT:  irq_count_d  = bus_data_i;
        ADDR_IRQ_RELOAD: irq_reload_d = bus_data_i;
        ADDR_IRQ_OFF_A, ADDR_IRQ_OFF_B: irq_on_d = 1'b0;
        ADDR_IRQ_ON_A, ADDR_IRQ_ON_B:   irq_on_d = 1'b1;
        default: ;
      endcase
    end
  end

  assign job_o      = job;
  assign job_push_o = accept_i & job_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_count_q   <= 9'd256;
      chr_present_q <= 1'b1;
      four_screen_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PRG_COUNT:   prg_count_q   <= cfg_wdata_i;
        CFG_CHR_PRESENT: chr_present_q <= cfg_wdata_i[0];
        CFG_FOUR_SCREEN: four_screen_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_select_q <= '0;
      ext_enabled_q <= 1'b0;
      ext_mode_q    <= '0;
      prg_a_q       <= 8'd0;
      prg_b_q       <= 8'd1;
      ext_prg_a_q   <= 8'd0;
      ext_prg_b_q   <= 8'd1;
      chr_q         <= CHR_RESET;
      irq_on_q      <= 1'b0;
      irq_count_q   <= '0;
      irq_reload_q  <= '0;
    end else if (accept_i) begin
      bank_select_q <= bank_select_d;
      ext_enabled_q <= ext_enabled_d;
      ext_mode_q    <= ext_mode_d;
      prg_a_q       <= prg_a_d;
      prg_b_q       <= prg_b_d;
      ext_prg_a_q   <= ext_prg_a_d;
      ext_prg_b_q   <= ext_prg_b_d;
      chr_q         <= chr_d;
      irq_on_q      <= irq_on_d;
      irq_count_q   <= irq_count_d;
      irq_reload_q  <= irq_reload_d;
    end
  end

endmodule

FILE: rtl/bsm_jobq.sv
// Small queue of pending update runs between the decoder and the sequencer.
module bsm_jobq
  import bsm_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t head_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wrap_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= wrap_inc(rd_ptr_q);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CW'(1);
        2'b01:   count_q <= count_q - CW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i) else $error("job pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("job popped from an empty queue");
`endif

endmodule

FILE: rtl/bsm_back.sv
// Back end: steps a run one slot update per cycle into an empty or popped output register.
module bsm_back
  import bsm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  job_t       head_i,
  input  logic       head_valid_i,
  output logic       head_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [1:0] update_kind_o,
  output logic [2:0] slot_index_o,
  output logic [7:0] bank_value_o,
  output logic       last_of_run_o
);

  logic [2:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  kind_e      kind_q;
  logic [2:0] slot_q;
  bank_t      bank_q;
  logic       last_q;
  logic       emit;
  logic       is_last;

  assign emit       = head_valid_i && (!out_valid_q || pop_i);
  assign is_last    = (idx_q == head_i.last_idx);
  assign head_pop_o = emit && is_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (pop_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      idx_d       = is_last ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q <= head_i.kind;
      slot_q <= head_i.first_slot + idx_q;
      bank_q <= head_i.banks[idx_q];
      last_q <= is_last;
    end
  end

  assign empty_o       = !out_valid_q;
  assign update_kind_o = kind_q;
  assign slot_index_o  = slot_q;
  assign bank_value_o  = bank_q;
  assign last_of_run_o = last_q;

`ifndef ASSERT_OFF
  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> idx_q <= head_i.last_idx) else $error("slot step beyond end of run");
  a_irq_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == KIND_IRQ) |-> (slot_q == 3'd0 && bank_q == 8'd0 && last_q))
    else $error("malformed interrupt result");
`endif

endmodule

FILE: rtl/bank_switch_mapper_with_scanline_irq.sv
// Top level of the bank switch mapper with scanline interrupt counter.
// This block tracks the bank registers of a cartridge mapper and reports every change of
// the memory map as a run of slot updates: four 8K program slots, eight 1K character
// slots, the mirroring choice, or an interrupt request. Each input transaction is either
// a CPU bus write or an end-of-scanline tick; the last update of its run carries
// last_of_run_o, and a transaction may cause no update at all. The decoder accepts one
// transaction per clock while the job queue has room, and the sequencer delivers one
// update per clock while its output register is empty or being popped; a run holds eight
// updates for a character bank change, four for a program bank change, two for the narrow
// extended pair and one otherwise. The output register is reloaded in the same cycle its
// update is popped, so a receiver that pops every cycle sees one update per clock.
// The reset mapping itself is never reported. Configuration writes are taken at once
// and must only be made while no transaction is in flight.
module bank_switch_mapper_with_scanline_irq
  import bsm_pkg::*;
#(
  parameter int unsigned JOB_DEPTH = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [CFG_WIDTH-1:0] cfg_wdata_i,
  input  logic                 push,
  output logic                 full,
  input  logic                 action_i,
  input  logic [15:0]          bus_address_i,
  input  logic [7:0]           bus_data_i,
  input  logic [8:0]           line_number_i,
  input  logic                 rendering_on_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [1:0]           update_kind_o,
  output logic [2:0]           slot_index_o,
  output logic [7:0]           bank_value_o,
  output logic                 last_of_run_o
);

  job_t job;
  job_t head;
  logic job_push;
  logic head_valid;
  logic head_pop;
  logic accept;

  // A transaction is taken whenever the job queue has room; state updates at once.
  assign accept = push && !full;

  bsm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .accept_i       (accept),
    .action_i       (action_i),
    .bus_address_i  (bus_address_i),
    .bus_data_i     (bus_data_i),
    .line_number_i  (line_number_i),
    .rendering_on_i (rendering_on_i),
    .job_o          (job),
    .job_push_o     (job_push)
  );

  // Runs wait here so the decoder and the sequencer can stall independently.
  bsm_jobq #(
    .DEPTH (JOB_DEPTH)
  ) u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job),
    .full_o  (full),
    .pop_i   (head_pop),
    .valid_o (head_valid),
    .head_o  (head)
  );

  bsm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .head_valid_i  (head_valid),
    .head_pop_o    (head_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .update_kind_o (update_kind_o),
    .slot_index_o  (slot_index_o),
    .bank_value_o  (bank_value_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

FILE: bench/map_checker.sv
// Checker that predicts the mapper's slot updates and compares every popped update.
`timescale 1ns / 1ps
module map_checker
  import bsm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [CFG_WIDTH-1:0] cfg_wdata_i,
  input  logic                 push,
  input  logic                 full,
  input  logic                 action_i,
  input  logic [15:0]          bus_address_i,
  input  logic [7:0]           bus_data_i,
  input  logic [8:0]           line_number_i,
  input  logic                 rendering_on_i,
  input  logic                 empty,
  input  logic                 pop,
  input  logic [1:0]           update_kind_o,
  input  logic [2:0]           slot_index_o,
  input  logic [7:0]           bank_value_o,
  input  logic                 last_of_run_o,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam bank_t EXT_DIRECT_BIT  = 8'h80;
  localparam bank_t EXT_WIDE_BIT    = 8'h20;
  localparam bank_t EXT_WIDE_MASK   = 8'h1E;
  localparam bank_t EXT_NARROW_MASK = 8'h1F;
  localparam bank_t EXT_KEEP_MASK   = 8'hF0;
  localparam bank_t SEL_PRG_SWAP    = 8'h40;
  localparam bank_t SEL_CHR_SWAP    = 8'h80;
  localparam bank_t CHR_2K_MASK     = 8'hFE;
  localparam logic [2:0] SEL_LAST_2K  = 3'd1;
  localparam logic [2:0] SEL_LAST_CHR = 3'd5;
  localparam logic [2:0] SEL_PRG_A    = 3'd6;

  typedef struct packed {
    kind_e      kind;
    logic [2:0] slot;
    bank_t      bank;
    logic       last;
  } slot_update_t;

  slot_update_t expected_q[$];
  int           fails;

  logic [8:0] prg_count;
  logic       chr_present;
  logic       four_screen;
  bank_t      bank_select;
  logic       ext_enabled;
  bank_t      ext_mode;
  bank_t      prg_a;
  bank_t      prg_b;
  bank_t      ext_prg_a;
  bank_t      ext_prg_b;
  chr_regs_t  chr;
  logic       irq_on;
  bank_t      irq_count;
  bank_t      irq_reload;

  // The two fixed banks sit at the top of the program space, wrapped to eight bits.
  function automatic bank_t fixed_bank(input logic [8:0] back);
    logic [8:0] diff;
    diff = prg_count - back;
    return diff[7:0];
  endfunction

  task automatic add_update(input kind_e k, input logic [2:0] s, input bank_t b);
    slot_update_t u;
    u.kind = k;
    u.slot = s;
    u.bank = b;
    u.last = 1'b0;
    expected_q.push_back(u);
  endtask

  task automatic add_prg_slots(input bank_t b0, input bank_t b1, input bank_t b2,
                               input bank_t b3);
    add_update(KIND_PRG, 3'd0, b0);
    add_update(KIND_PRG, 3'd1, b1);
    add_update(KIND_PRG, 3'd2, b2);
    add_update(KIND_PRG, 3'd3, b3);
  endtask

  task automatic add_program_map();
    if ((bank_select & SEL_PRG_SWAP) != 0) begin
      add_prg_slots(fixed_bank(9'd2), prg_b, prg_a, fixed_bank(9'd1));
    end else begin
      add_prg_slots(prg_a, prg_b, fixed_bank(9'd2), fixed_bank(9'd1));
    end
  endtask

  task automatic add_character_map();
    bank_t lo[4];
    bank_t hi[4];
    logic  swap;
    int    i;
    if (!chr_present) return;
    swap  = (bank_select & SEL_CHR_SWAP) != 0;
    lo[0] = chr[0];
    lo[1] = chr[0] + 8'd1;
    lo[2] = chr[1];
    lo[3] = chr[1] + 8'd1;
    for (i = 0; i < 4; i++) hi[i] = chr[2 + i];
    for (i = 0; i < 4; i++) add_update(KIND_CHR, i[2:0], swap ? hi[i] : lo[i]);
    for (i = 0; i < 4; i++) add_update(KIND_CHR, 3'd4 + i[2:0], swap ? lo[i] : hi[i]);
  endtask

  task automatic apply_bus_write(input logic [15:0] addr, input bank_t data);
    logic [2:0] sel;
    bank_t      b;
    case (addr)
      ADDR_EXT_MODE: begin
        if ((data & EXT_DIRECT_BIT) != 0) begin
          if ((data & EXT_WIDE_BIT) != 0) begin
            b = (data & EXT_WIDE_MASK) << 1;
            add_prg_slots(b, b + 8'd1, b + 8'd2, b + 8'd3);
          end else begin
            b = (data & EXT_NARROW_MASK) << 1;
            add_update(KIND_PRG, 3'd1, b);
            add_update(KIND_PRG, 3'd2, b + 8'd1);
          end
        end else begin
          add_prg_slots(ext_prg_a, ext_prg_b, fixed_bank(9'd2), fixed_bank(9'd1));
        end
        ext_mode = data;
      end
      ADDR_BANK_SEL: begin
        ext_enabled = 1'b0;
        bank_select = data;
        add_character_map();
      end
      ADDR_BANK_DATA: begin
        if (ext_enabled) begin
          if (bank_select == EXT_SEL_SLOT1) add_update(KIND_PRG, 3'd1, EXT_BANK_SLOT1);
          if (bank_select == EXT_SEL_SLOT2) add_update(KIND_PRG, 3'd2, EXT_BANK_SLOT2);
        end else begin
          sel = bank_select[2:0];
          if (sel <= SEL_LAST_CHR) begin
            if (chr_present) begin
              chr[sel] = (sel <= SEL_LAST_2K) ? (data & CHR_2K_MASK) : data;
              add_character_map();
            end
          end else if (sel == SEL_PRG_A) begin
            // A locked extended mode keeps the live register but still shadows it.
            if ((ext_mode & EXT_LOCK_MASK) != EXT_LOCK_MASK) begin
              prg_a = data;
              add_program_map();
            end
            ext_prg_a = data;
          end else begin
            if ((ext_mode & EXT_LOCK_MASK) != EXT_LOCK_MASK) begin
              prg_b = data;
              add_program_map();
            end
            ext_prg_b = data;
          end
        end
      end
      ADDR_EXT_ENABLE: begin
        ext_enabled = 1'b1;
        if ((data & EXT_KEEP_MASK) == 0) add_update(KIND_PRG, 3'd2, fixed_bank(9'd2));
      end
      ADDR_MIRROR: begin
        if (!four_screen) add_update(KIND_MIRROR, 3'd0, {7'd0, data[0]});
      end
      ADDR_IRQ_COUNT:                 irq_count = data;
      ADDR_IRQ_RELOAD:                irq_reload = data;
      ADDR_IRQ_OFF_A, ADDR_IRQ_OFF_B: irq_on = 1'b0;
      ADDR_IRQ_ON_A, ADDR_IRQ_ON_B:   irq_on = 1'b1;
      default: ;
    endcase
  endtask

  // Appends the updates of one accepted transaction and flags the last of them.
  task automatic predict_transaction();
    int           start;
    slot_update_t u;
    start = expected_q.size();
    if (!action_i) begin
      apply_bus_write(bus_address_i, bus_data_i);
    end else if (irq_on && line_number_i <= LAST_VISIBLE_LINE && rendering_on_i) begin
      if (irq_count == 0) begin
        irq_count = irq_reload;
        add_update(KIND_IRQ, 3'd0, 8'd0);
      end else begin
        irq_count = irq_count - 8'd1;
      end
    end
    if (expected_q.size() > start) begin
      u      = expected_q.pop_back();
      u.last = 1'b1;
      expected_q.push_back(u);
    end
  endtask

  task automatic check_update();
    slot_update_t want;
    if (expected_q.size() == 0) begin
      $error("unexpected update: kind %0d slot %0d bank %0d last %0d",
             update_kind_o, slot_index_o, bank_value_o, last_of_run_o);
      fails++;
    end else begin
      want = expected_q.pop_front();
      if (update_kind_o !== want.kind) begin
        $error("update_kind: expected %0d, actual %0d", want.kind, update_kind_o);
        fails++;
      end
      if (slot_index_o !== want.slot) begin
        $error("slot_index: expected %0d, actual %0d", want.slot, slot_index_o);
        fails++;
      end
      if (bank_value_o !== want.bank) begin
        $error("bank_value: expected %0d, actual %0d", want.bank, bank_value_o);
        fails++;
      end
      if (last_of_run_o !== want.last) begin
        $error("last_of_run: expected %0d, actual %0d", want.last, last_of_run_o);
        fails++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_count    = 9'd256;
      chr_present  = 1'b1;
      four_screen  = 1'b0;
      bank_select  = 8'd0;
      ext_enabled  = 1'b0;
      ext_mode     = 8'd0;
      prg_a        = 8'd0;
      prg_b        = 8'd1;
      ext_prg_a    = 8'd0;
      ext_prg_b    = 8'd1;
      chr[0]       = 8'd0;
      chr[1]       = 8'd2;
      chr[2]       = 8'd4;
      chr[3]       = 8'd5;
      chr[4]       = 8'd6;
      chr[5]       = 8'd7;
      irq_on       = 1'b0;
      irq_count    = 8'd0;
      irq_reload   = 8'd0;
      fails        = 0;
      expected_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PRG_COUNT:   prg_count = cfg_wdata_i;
          CFG_CHR_PRESENT: chr_present = cfg_wdata_i[0];
          CFG_FOUR_SCREEN: four_screen = cfg_wdata_i[0];
          default: ;
        endcase
      end
      // A result popped at this edge can only belong to an earlier transaction.
      if (pop && !empty) check_update();
      if (push && !full) predict_transaction();
      fail_count_o <= fails;
      pending_o    <= expected_q.size();
    end
  end

endmodule

FILE: bench/testbench.sv
// Top of the mapper testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module testbench;
  import bsm_pkg::*;

  // Cycles allowed without any handshake before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // Cycles to let a transaction that causes no update finish inside the block.
  localparam int SETTLE_CYCLES  = 24;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_we_i       = 1'b0;
  logic [1:0]           cfg_idx_i      = CFG_PRG_COUNT;
  logic [CFG_WIDTH-1:0] cfg_wdata_i    = '0;
  logic                 push           = 1'b0;
  logic                 full;
  logic                 action_i       = 1'b0;
  logic [15:0]          bus_address_i  = '0;
  logic [7:0]           bus_data_i     = '0;
  logic [8:0]           line_number_i  = '0;
  logic                 rendering_on_i = 1'b0;
  logic                 empty;
  logic                 pop            = 1'b0;
  logic [1:0]           update_kind_o;
  logic [2:0]           slot_index_o;
  logic [7:0]           bank_value_o;
  logic                 last_of_run_o;
  int                   fail_count_o;
  int                   pending_o;

  // Gap before the next push; drawn when a transaction is accepted so that push can
  // stay high through back-to-back transactions.
  int next_gap       = 0;
  bit sender_fast    = 1'b0;
  bit receiver_fast  = 1'b0;
  int idle_cycles    = 0;

  bank_switch_mapper_with_scanline_irq dut (.*);

  map_checker map_check (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // The watchdog restarts on every accepted transaction, result or register write.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The receiver stalls a random number of cycles before each result, with
  // occasional stretches in which it pops every cycle.
  initial begin
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) receiver_fast = !receiver_fast;
      gap = receiver_fast ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  // Presents one transaction after the pending gap and holds it until accepted.
  // Push is only lowered here when the next transaction will not follow at once.
  task automatic send_item(input logic act, input logic [15:0] addr, input logic [7:0] data,
                           input logic [8:0] line, input logic rend);
    repeat (next_gap) @(posedge clk_i);
    push           <= 1'b1;
    action_i       <= act;
    bus_address_i  <= addr;
    bus_data_i     <= data;
    line_number_i  <= line;
    rendering_on_i <= rend;
    do @(posedge clk_i); while (full);
    if ($urandom_range(0, 39) == 0) sender_fast = !sender_fast;
    next_gap = sender_fast ? 0 : $urandom_range(0, 13);
    if (next_gap != 0) push <= 1'b0;
  endtask

  // Tick fields ride along with bus writes at random since the block ignores them.
  task automatic bus_write(input logic [15:0] addr, input logic [7:0] data);
    send_item(1'b0, addr, data, 9'($urandom_range(0, 511)), 1'($urandom_range(0, 1)));
  endtask

  task automatic scan_tick(input logic [8:0] line, input logic rend);
    send_item(1'b1, 16'($urandom), 8'($urandom), line, rend);
  endtask

  // Stops the sender and waits until every predicted update has been popped, then
  // gives a transaction with no update time to leave the pipeline.
  task automatic drain();
    if (next_gap == 0) push <= 1'b0;
    next_gap = 0;
    do @(posedge clk_i); while (pending_o != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register writes go out back to back once the block is idle.
  task automatic configure(input logic [8:0] prg_count, input logic chr_present,
                           input logic four_screen);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_PRG_COUNT;
    cfg_wdata_i <= prg_count;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_CHR_PRESENT;
    cfg_wdata_i <= {8'd0, chr_present};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_FOUR_SCREEN;
    cfg_wdata_i <= {8'd0, four_screen};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Picks one of the decoded addresses, favoring the bank select and bank data
  // pair since they drive most of the mapping.
  function automatic logic [15:0] pick_address();
    case ($urandom_range(0, 15))
      0:       return ADDR_EXT_MODE;
      1, 2, 3: return ADDR_BANK_SEL;
      4, 5, 6: return ADDR_BANK_DATA;
      7:       return ADDR_EXT_ENABLE;
      8:       return ADDR_MIRROR;
      9:       return ADDR_IRQ_COUNT;
      10:      return ADDR_IRQ_RELOAD;
      11:      return ADDR_IRQ_OFF_A;
      12:      return ADDR_IRQ_ON_A;
      13:      return ADDR_IRQ_OFF_B;
      14:      return ADDR_IRQ_ON_B;
      default: return 16'hA001;
    endcase
  endfunction

  // One random transaction. Returns 1 for noise, a write to a random or bit-flipped address
  // that may still be a decoded one, so the caller does not count it.
  function automatic bit random_item_is_noise(output logic act, output logic [15:0] addr,
                                              output logic [7:0] data);
    int roll;
    roll = $urandom_range(0, 99);
    act  = 1'b0;
    data = 8'($urandom);
    if (roll < 55) begin
      addr = pick_address();
      // Small counter values make interrupt requests frequent; the extended select
      // values open the special bank data path after an extended enable.
      if ((addr == ADDR_IRQ_COUNT || addr == ADDR_IRQ_RELOAD) && $urandom_range(0, 1))
        data = 8'($urandom_range(0, 3));
      if (addr == ADDR_BANK_SEL && $urandom_range(0, 3) == 0)
        data = $urandom_range(0, 1) ? EXT_SEL_SLOT1 : EXT_SEL_SLOT2;
      if (addr == ADDR_EXT_ENABLE && $urandom_range(0, 1)) data = data & 8'h0F;
      return 1'b0;
    end
    if (roll < 85) begin
      act  = 1'b1;
      addr = '0;
      return 1'b0;
    end
    // Noise: a fully random address, or a decoded one with a single bit flipped.
    if ($urandom_range(0, 1)) addr = 16'($urandom);
    else addr = pick_address() ^ (16'd1 << $urandom_range(0, 15));
    return 1'b1;
  endfunction

  // Random transactions until the given number of meaningful ones has gone out.
  // Halfway through, the sender holds off until every result has arrived.
  task automatic random_phase(input int count);
    int          sent;
    bit          noise;
    logic        act;
    logic [15:0] addr;
    logic [7:0]  data;
    sent = 0;
    while (sent < count) begin
      noise = random_item_is_noise(act, addr, data);
      if (act) begin
        if ($urandom_range(0, 3) == 0) scan_tick(9'($urandom_range(240, 511)), 1'b1);
        else scan_tick(9'($urandom_range(0, 239)), $urandom_range(0, 9) != 0);
      end else begin
        bus_write(addr, data);
      end
      if (!noise) sent++;
      if (sent == count / 2 && !noise) drain();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with the reset configuration written explicitly.
    configure(9'd256, 1'b1, 1'b0);
    // Extended mode: narrow pair, wide quad that also locks the program registers.
    bus_write(ADDR_EXT_MODE, 8'h9F);
    bus_write(ADDR_EXT_MODE, 8'hBE);
    bus_write(ADDR_BANK_SEL, 8'h06);
    // Locked: only the shadow register takes the value, nothing is reported.
    bus_write(ADDR_BANK_DATA, 8'h33);
    // Extended mode off maps the shadow registers and the fixed banks.
    bus_write(ADDR_EXT_MODE, 8'h00);
    // Both swap bits set, then the second program register at its extreme.
    bus_write(ADDR_BANK_SEL, 8'hC7);
    bus_write(ADDR_BANK_DATA, 8'hFF);
    // A 2K character bank at the top has its low bit cleared, so its halves are FE and FF.
    bus_write(ADDR_BANK_SEL, 8'h00);
    bus_write(ADDR_BANK_DATA, 8'hFF);
    // Extended enable followed by the two special bank data selects.
    bus_write(ADDR_BANK_SEL, EXT_SEL_SLOT1);
    bus_write(ADDR_EXT_ENABLE, 8'h00);
    bus_write(ADDR_BANK_DATA, 8'h55);
    bus_write(ADDR_BANK_SEL, EXT_SEL_SLOT2);
    bus_write(ADDR_EXT_ENABLE, 8'hF0);
    bus_write(ADDR_BANK_DATA, 8'h00);
    bus_write(ADDR_MIRROR, 8'h01);
    // Counter at zero with the interrupt on: the first counted tick underflows.
    bus_write(ADDR_IRQ_COUNT, 8'h00);
    bus_write(ADDR_IRQ_RELOAD, 8'h02);
    bus_write(ADDR_IRQ_ON_A, 8'h00);
    scan_tick(9'd0, 1'b1);
    scan_tick(LAST_VISIBLE_LINE, 1'b1);
    scan_tick(9'd240, 1'b1);
    // An address that only absorbs its data, and an unmapped one.
    bus_write(16'hA001, 8'hFF);
    bus_write(16'hFFFF, 8'hFF);
    bus_write(ADDR_IRQ_OFF_A, 8'h00);

    // Random phases across several settings, the extremes among them.
    configure(9'd2, 1'b1, 1'b1);
    random_phase(70);
    configure(9'd2, 1'b0, 1'b0);
    random_phase(60);
    configure(9'($urandom_range(3, 255)), 1'b1, 1'b0);
    random_phase(70);
    configure(9'd256, 1'b1, 1'b1);
    random_phase(70);

    drain();
    if (fail_count_o == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bsm_pkg.sv
rtl/bsm_front.sv
rtl/bsm_jobq.sv
rtl/bsm_back.sv
rtl/bank_switch_mapper_with_scanline_irq.sv
bench/map_checker.sv
bench/testbench.sv
